/* hw/rtl/hezr_pkg.sv */
// Hall-edge position zeroing: shared types, register codes and saturating arithmetic.
// No dependencies; used by hezr_core and hall_edge_position_zeroing.
package hezr_pkg;

   localparam int PosWidth = 32;
   localparam int CountWidth = 32;
   localparam int RunWidth = 16;
   localparam int CsrIndexWidth = 8;

   localparam logic signed [PosWidth-1:0] POS_MAX = {1'b0, {(PosWidth-1){1'b1}}};
   localparam logic signed [PosWidth-1:0] POS_MIN = {1'b1, {(PosWidth-1){1'b0}}};
   localparam logic [RunWidth-1:0] RUN_MAX = {RunWidth{1'b1}};

   // register indexes on the csr port
   localparam logic [CsrIndexWidth-1:0] CSR_TRIGGER_LENGTH = 8'd0;
   localparam logic [CsrIndexWidth-1:0] CSR_MOVE_DIRECTION = 8'd1;
   localparam logic [CsrIndexWidth-1:0] CSR_LOWER_HALL_POS = 8'd2;
   localparam logic [CsrIndexWidth-1:0] CSR_UPPER_HALL_POS = 8'd3;

   typedef struct packed {
      logic                        hall_level;
      logic signed [PosWidth-1:0]  encoder_pos;
      logic [CountWidth-1:0]       edge_count;
      logic signed [PosWidth-1:0]  edge_pos;
      logic                        force_error;
   } req_word_type;

   typedef struct packed {
      logic signed [PosWidth-1:0]  corrected_pos;
      logic signed [PosWidth-1:0]  offset_out;
      logic                        is_zeroed;
      logic                        high_enough;
      logic                        error_flag;
   } rsp_word_type;

   typedef struct packed {
      logic [RunWidth-1:0]         trigger_length;
      logic                        move_direction;
      logic signed [PosWidth-1:0]  lower_hall_pos;
      logic signed [PosWidth-1:0]  upper_hall_pos;
   } cfg_type;

   // a - b clamped to the signed range
   function automatic logic signed [PosWidth-1:0] sat_sub(
      input logic signed [PosWidth-1:0] a,
      input logic signed [PosWidth-1:0] b
   );
      logic signed [PosWidth:0] d;
      d = $signed({a[PosWidth-1], a}) - $signed({b[PosWidth-1], b});
      if (d[PosWidth] != d[PosWidth-1]) begin
         return d[PosWidth] ? POS_MIN : POS_MAX;
      end
      return d[PosWidth-1:0];
   endfunction

endpackage

/* hw/rtl/hezr_core.sv */
// Zeroing state and per-word update: low-window min/max, high run, edge qualification.
// Depends on hezr_pkg.
module hezr_core (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  hezr_pkg::cfg_type     cfg,
   input  hezr_pkg::req_word_type word,
   output hezr_pkg::rsp_word_type result
);

   logic signed [hezr_pkg::PosWidth-1:0]  offset_ff, offset_in;
   logic signed [hezr_pkg::PosWidth-1:0]  low_min_ff, low_min_in;
   logic signed [hezr_pkg::PosWidth-1:0]  low_max_ff, low_max_in;
   logic [hezr_pkg::CountWidth-1:0]       used_ff, used_in;
   logic [hezr_pkg::RunWidth-1:0]         run_ff, run_in;
   logic zeroed_ff, zeroed_in;
   logic seen_ff;
   logic prev_ff;
   logic err_ff, err_in;

   logic [hezr_pkg::CountWidth-1:0] used_base, used_mid;
   logic prev_eff;
   logic high_ok;
   logic backward;
   logic fire;

   always_comb begin
      err_in    = err_ff | word.force_error;
      // first word after reset seeds the edge count and hall history
      used_base = seen_ff ? used_ff : word.edge_count;
      prev_eff  = seen_ff ? prev_ff : word.hall_level;

      low_min_in = low_min_ff;
      low_max_in = low_max_ff;
      if (!word.hall_level) begin
         if (prev_eff) begin
            low_min_in = word.encoder_pos;
            low_max_in = word.encoder_pos;
         end else begin
            if (word.encoder_pos < low_min_ff) low_min_in = word.encoder_pos;
            if (word.encoder_pos > low_max_ff) low_max_in = word.encoder_pos;
         end
      end

      if (word.hall_level) begin
         run_in   = (run_ff == hezr_pkg::RUN_MAX) ? run_ff : run_ff + 1'b1;
         used_mid = used_base;
      end else begin
         run_in   = '0;
         used_mid = word.edge_count;
      end

      high_ok  = run_in >= cfg.trigger_length;
      backward = cfg.move_direction ? (word.encoder_pos > low_min_in)
                                    : (word.encoder_pos < low_max_in);
      fire     = (used_mid != word.edge_count) && high_ok && backward;

      offset_in = offset_ff;
      used_in   = used_mid;
      zeroed_in = zeroed_ff;
      if (fire) begin
         offset_in = hezr_pkg::sat_sub(
            cfg.move_direction ? cfg.lower_hall_pos : cfg.upper_hall_pos, word.edge_pos);
         used_in   = word.edge_count;
         zeroed_in = 1'b1;
      end

      result.corrected_pos = hezr_pkg::sat_sub(word.encoder_pos, offset_in);
      result.offset_out    = offset_in;
      result.is_zeroed     = zeroed_in;
      result.high_enough   = high_ok;
      result.error_flag    = err_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff  <= '0;
         low_min_ff <= hezr_pkg::POS_MAX;
         low_max_ff <= hezr_pkg::POS_MIN;
         used_ff    <= '0;
         run_ff     <= '0;
         zeroed_ff  <= 1'b0;
         seen_ff    <= 1'b0;
         prev_ff    <= 1'b0;
         err_ff     <= 1'b0;
      end else if (advance) begin
         offset_ff  <= offset_in;
         low_min_ff <= low_min_in;
         low_max_ff <= low_max_in;
         used_ff    <= used_in;
         run_ff     <= run_in;
         zeroed_ff  <= zeroed_in;
         seen_ff    <= 1'b1;
         prev_ff    <= word.hall_level;
         err_ff     <= err_in;
      end
   end

endmodule

/* hw/rtl/hall_edge_position_zeroing.sv */
// Top level of the hall-edge position zeroing block: csr bank, input and result registers.
// Depends on hezr_pkg and hezr_core.
//
// Takes one sensor sample per word (hall level, Q16.16 encoder position, hall rising-edge
// count, position latched at that edge, error strobe) and returns exactly one result word
// per sample: the corrected position, current offset and status flags. A word is taken
// in every cycle while the result side keeps up. After a word is accepted on req_, it sits
// in the input register, the single update step between the two registers works on it,
// and it loads into the result register, raising rsp_valid, once that register is free.
// While a finished result waits on rsp_stall the input register still takes one more
// word. Register writes on csr_ are always ready and should land only while no word is
// in flight; an unknown index is ignored.
module hall_edge_position_zeroing (
   input  logic                                  clock,
   input  logic                                  reset,
   // sample words
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  hezr_pkg::req_word_type                req_word,
   // result words
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output hezr_pkg::rsp_word_type                rsp_word,
   // register writes
   input  logic                                  csr_valid,
   output logic                                  csr_ready,
   input  logic [hezr_pkg::CsrIndexWidth-1:0]    csr_index,
   input  logic [hezr_pkg::PosWidth-1:0]         csr_data
);

   hezr_pkg::cfg_type       cfg_ff;
   hezr_pkg::req_word_type  in_word_ff;
   logic                    in_vld_ff;
   hezr_pkg::rsp_word_type  out_word_ff;
   logic                    out_vld_ff;
   hezr_pkg::rsp_word_type  core_result;

   logic out_take;   // result register can load this cycle
   logic advance;    // input register word moves into the result register
   logic in_take;    // new sample word accepted

   assign csr_ready = 1'b1;

   // csr bank
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.trigger_length <= hezr_pkg::RunWidth'(1);
         cfg_ff.move_direction <= 1'b0;
         cfg_ff.lower_hall_pos <= '0;
         cfg_ff.upper_hall_pos <= '0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            hezr_pkg::CSR_TRIGGER_LENGTH:
               cfg_ff.trigger_length <= csr_data[hezr_pkg::RunWidth-1:0];
            hezr_pkg::CSR_MOVE_DIRECTION: cfg_ff.move_direction <= csr_data[0];
            hezr_pkg::CSR_LOWER_HALL_POS: cfg_ff.lower_hall_pos <= $signed(csr_data);
            hezr_pkg::CSR_UPPER_HALL_POS: cfg_ff.upper_hall_pos <= $signed(csr_data);
            default: ;
         endcase
      end
   end

   // flow control: the result register frees when empty or being taken,
   // the input register frees when empty or moving on
   assign out_take  = !out_vld_ff || !rsp_stall;
   assign advance   = in_vld_ff && out_take;
   assign req_stall = in_vld_ff && !out_take;
   assign in_take   = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
      end else if (in_take) begin
         in_vld_ff <= 1'b1;
      end else if (advance) begin
         in_vld_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         in_word_ff <= req_word;
      end
   end

   hezr_core u_core (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .cfg     (cfg_ff),
      .word    (in_word_ff),
      .result  (core_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff <= 1'b0;
      end else if (out_take) begin
         out_vld_ff <= in_vld_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_word_ff <= core_result;
      end
   end

   assign rsp_valid = out_vld_ff;
   assign rsp_word  = out_word_ff;

   // the input side only stalls behind a full, stalled result register
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("input stalled without a blocked result");

   // a held input word is never dropped
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      (in_vld_ff && !advance) |=> in_vld_ff)
      else $error("input word lost while blocked");

   // the offset only moves when a qualified edge also sets the zeroed flag
   a_offset_zeroed: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_word.is_zeroed) |-> (rsp_word.offset_out == '0))
      else $error("offset non-zero before zeroing");

endmodule

/* tb/sv/testbench.sv */
// Self-checking testbench for hall_edge_position_zeroing: directed and random sample words
// against an in-bench predictor of the zeroing logic. Depends on hezr_pkg and the block's RTL.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [hezr_pkg::PosWidth-1:0] pos_type;

   // cycles with no handshake at all before the run is declared hung
   localparam int QuietLimit = 5000;
   // drain time after the last result, to catch any stray word at the end
   localparam int DrainCycles = 8;
   // keep a broken design from flooding the log
   localparam int MaxReported = 40;
   // trigger length used for the long high stretch
   localparam int LongRun = 150;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                                 req_valid = 1'b0;
   logic                                 req_stall;
   hezr_pkg::req_word_type               req_word = '0;
   logic                                 rsp_valid;
   logic                                 rsp_stall = 1'b0;
   hezr_pkg::rsp_word_type               rsp_word;
   logic                                 csr_valid = 1'b0;
   logic                                 csr_ready;
   logic [hezr_pkg::CsrIndexWidth-1:0]   csr_index = '0;
   logic [hezr_pkg::PosWidth-1:0]        csr_data = '0;

   hall_edge_position_zeroing i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------------------
   // Predictor: mirrors the registers and the zeroing state, advanced once per accepted word
   // ---------------------------------------------------------------------------------------
   hezr_pkg::cfg_type   cfg_now = '{trigger_length: 16'd1, move_direction: 1'b0,
                                    lower_hall_pos: '0, upper_hall_pos: '0};
   pos_type             zero_offset = '0;
   pos_type             win_min = hezr_pkg::POS_MAX;   // lowest position seen while hall is low
   pos_type             win_max = hezr_pkg::POS_MIN;   // highest position seen while hall is low
   logic [hezr_pkg::CountWidth-1:0] last_edge_count = '0;
   logic [hezr_pkg::RunWidth-1:0]   high_count = '0;
   logic                high_seen = 1'b0;
   logic                zeroed = 1'b0;
   logic                started = 1'b0;
   logic                hall_was = 1'b0;
   logic                error_latched = 1'b0;

   hezr_pkg::rsp_word_type expected_results[$];
   int                  words_sent = 0;
   int                  results_seen = 0;
   int                  mismatches = 0;

   // a - b, clamped to the Q16.16 range
   function automatic pos_type clamp_diff(input pos_type a, input pos_type b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d > longint'(hezr_pkg::POS_MAX)) return hezr_pkg::POS_MAX;
      if (d < longint'(hezr_pkg::POS_MIN)) return hezr_pkg::POS_MIN;
      return pos_type'(d);
   endfunction

   function automatic hezr_pkg::rsp_word_type advance_zeroing(input hezr_pkg::req_word_type w);
      hezr_pkg::rsp_word_type r;
      pos_type      enc;
      pos_type      latched;
      logic         backward;
      enc = w.encoder_pos;
      latched = w.edge_pos;
      if (w.force_error) error_latched = 1'b1;
      // very first word seeds the edge count and the previous hall level
      if (!started) begin
         last_edge_count = w.edge_count;
         hall_was = w.hall_level;
         started = 1'b1;
      end
      if (!w.hall_level) begin
         if (hall_was) begin
            // falling edge: fresh low window
            win_min = enc;
            win_max = enc;
         end else begin
            if (enc < win_min) win_min = enc;
            if (enc > win_max) win_max = enc;
         end
      end
      hall_was = w.hall_level;
      if (w.hall_level) begin
         if (high_count != hezr_pkg::RUN_MAX) high_count = high_count + 1'b1;
      end else begin
         high_count = '0;
         last_edge_count = w.edge_count;
      end
      high_seen = high_count >= cfg_now.trigger_length;
      backward = cfg_now.move_direction ? (enc > win_min) : (enc < win_max);
      if (last_edge_count != w.edge_count && high_seen && backward) begin
         zero_offset = clamp_diff(cfg_now.move_direction ? cfg_now.lower_hall_pos
                                                         : cfg_now.upper_hall_pos, latched);
         last_edge_count = w.edge_count;
         zeroed = 1'b1;
      end
      r.corrected_pos = clamp_diff(enc, zero_offset);
      r.offset_out = zero_offset;
      r.is_zeroed = zeroed;
      r.high_enough = high_seen;
      r.error_flag = error_latched;
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] want,
                                  input logic [31:0] got);
      if (mismatches < MaxReported)
         $display("%0t: result %0d %s: expected %h, got %h", $realtime, results_seen, what,
                  want, got);
      mismatches++;
   endtask

   // ---------------------------------------------------------------------------------------
   // Scoreboard: check first, then predict, then mirror register writes, all on one edge
   // ---------------------------------------------------------------------------------------
   always @(posedge clock) begin
      hezr_pkg::rsp_word_type got;
      hezr_pkg::rsp_word_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            got = rsp_word;
            if (expected_results.size() == 0) begin
               report_mismatch("word with nothing expected", '0, got.corrected_pos);
            end else begin
               want = expected_results.pop_front();
               if (got.corrected_pos !== want.corrected_pos)
                  report_mismatch("corrected_pos", want.corrected_pos, got.corrected_pos);
               if (got.offset_out !== want.offset_out)
                  report_mismatch("offset_out", want.offset_out, got.offset_out);
               if (got.is_zeroed !== want.is_zeroed)
                  report_mismatch("is_zeroed", 32'(want.is_zeroed), 32'(got.is_zeroed));
               if (got.high_enough !== want.high_enough)
                  report_mismatch("high_enough", 32'(want.high_enough),
                                  32'(got.high_enough));
               if (got.error_flag !== want.error_flag)
                  report_mismatch("error_flag", 32'(want.error_flag), 32'(got.error_flag));
            end
            results_seen++;
         end
         if (req_valid && !req_stall) expected_results.push_back(advance_zeroing(req_word));
         if (csr_valid && csr_ready) begin
            case (csr_index)
               hezr_pkg::CSR_TRIGGER_LENGTH:
                  cfg_now.trigger_length = csr_data[hezr_pkg::RunWidth-1:0];
               hezr_pkg::CSR_MOVE_DIRECTION: cfg_now.move_direction = csr_data[0];
               hezr_pkg::CSR_LOWER_HALL_POS: cfg_now.lower_hall_pos = csr_data;
               hezr_pkg::CSR_UPPER_HALL_POS: cfg_now.upper_hall_pos = csr_data;
               default: ;   // unknown index: no effect
            endcase
         end
      end
   end

   // hang detector: any handshake restarts the count
   int quiet_cycles = 0;
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QuietLimit) begin
         $display("hall_edge_position_zeroing test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // ---------------------------------------------------------------------------------------
   // Drivers
   // ---------------------------------------------------------------------------------------
   int send_idle_pct = 0;
   int rsp_idle_pct = 0;

   // receiver back-pressure, redrawn every cycle
   always @(posedge clock) rsp_stall <= ($urandom_range(99) < rsp_idle_pct);

   task automatic send_fields(input logic hall, input pos_type enc, input logic [31:0] count,
                              input pos_type latched, input logic err);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_word <= '{hall, enc, count, latched, err};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      words_sent++;
   endtask

   // lowers valid and waits until every sent word has come back
   task automatic wait_for_results();
      req_valid <= 1'b0;
      while (results_seen != words_sent) @(posedge clock);
   endtask

   task automatic write_reg(input logic [hezr_pkg::CsrIndexWidth-1:0] idx,
                            input logic [31:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   // registers only change with the block empty; junk above the trigger and direction widths
   task automatic apply_config(input hezr_pkg::cfg_type c, input bit bad_index);
      wait_for_results();
      write_reg(hezr_pkg::CSR_TRIGGER_LENGTH, {16'($urandom), c.trigger_length});
      write_reg(hezr_pkg::CSR_MOVE_DIRECTION, {31'($urandom), c.move_direction});
      write_reg(hezr_pkg::CSR_LOWER_HALL_POS, c.lower_hall_pos);
      write_reg(hezr_pkg::CSR_UPPER_HALL_POS, c.upper_hall_pos);
      if (bad_index)
         write_reg(hezr_pkg::CsrIndexWidth'($urandom_range(
                      (1 << hezr_pkg::CsrIndexWidth) - 1,
                      hezr_pkg::CSR_UPPER_HALL_POS + 1)), $urandom);
      csr_valid <= 1'b0;
   endtask

   function automatic pos_type pick_position();
      case ($urandom_range(7))
         0: return hezr_pkg::POS_MAX;
         1: return hezr_pkg::POS_MIN;
         2, 3: return pos_type'($urandom);
         default: return pos_type'($urandom_range(1 << 20)) - pos_type'(1 << 19);
      endcase
   endfunction

   function automatic hezr_pkg::cfg_type random_config();
      hezr_pkg::cfg_type c;
      case ($urandom_range(9))
         0: c.trigger_length = '0;
         1: c.trigger_length = hezr_pkg::RUN_MAX;
         2: c.trigger_length = hezr_pkg::RunWidth'($urandom);
         default: c.trigger_length = hezr_pkg::RunWidth'($urandom_range(6, 1));
      endcase
      c.move_direction = 1'($urandom);
      c.lower_hall_pos = pick_position();
      c.upper_hall_pos = pick_position();
      return c;
   endfunction

   function automatic logic rare_error();
      return $urandom_range(299) == 0;
   endfunction

   // ---------------------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------------------
   // simulated mechanism: encoder, edge counter and latched edge position
   pos_type           enc_track = '0;
   logic [31:0]       edge_total = '0;
   pos_type           edge_latch = '0;

   // reset values of the registers; first word high, counter wraps, window extremes
   task automatic test_first_sample();
      send_fields(1'b1, 1000, 32'hFFFF_FFFF, 0, 1'b0);
      send_fields(1'b1, 500, 32'h0, 200, 1'b0);      // new edge but window still empty
      send_fields(1'b0, 300, 32'h0, 200, 1'b0);      // falling edge restarts window
      send_fields(1'b0, hezr_pkg::POS_MAX, 32'h0, 200, 1'b0);
      send_fields(1'b0, hezr_pkg::POS_MIN, 32'h0, 200, 1'b0);
      send_fields(1'b1, 0, 32'h1, -7, 1'b0);         // qualified edge
      send_fields(1'b1, hezr_pkg::POS_MIN, 32'h1, 0, 1'b0);
      send_fields(1'b0, hezr_pkg::POS_MAX, 32'h1, 0, 1'b1);    // error strobe
   endtask

   // offset and corrected position clamping both ways, zero trigger, bad indexes
   task automatic test_saturation_and_registers();
      apply_config('{trigger_length: '0, move_direction: 1'b1,
                     lower_hall_pos: hezr_pkg::POS_MIN, upper_hall_pos: hezr_pkg::POS_MAX},
                   1'b1);
      send_fields(1'b0, 0, 32'h2, 0, 1'b0);
      send_fields(1'b0, 5, 32'h2, 0, 1'b0);
      send_fields(1'b1, 10, 32'h3, hezr_pkg::POS_MAX, 1'b0);
      send_fields(1'b1, -1, 32'h3, 0, 1'b0);
      apply_config('{trigger_length: 16'd1, move_direction: 1'b0,
                     lower_hall_pos: '0, upper_hall_pos: hezr_pkg::POS_MAX}, 1'b1);
      send_fields(1'b0, 0, 32'h4, 0, 1'b0);
      send_fields(1'b0, 9, 32'h4, 0, 1'b0);
      send_fields(1'b1, 3, 32'h5, hezr_pkg::POS_MIN, 1'b0);
      send_fields(1'b1, hezr_pkg::POS_MIN, 32'h5, 0, 1'b0);
      send_fields(1'b1, hezr_pkg::POS_MAX, 32'h5, 0, 1'b0);
      edge_total = 32'h5;
   endtask

   // long trigger length: high_enough stays low through the run, then rises and holds
   task automatic test_long_high_run();
      int i;
      send_idle_pct = 0;
      rsp_idle_pct = 0;
      apply_config('{trigger_length: hezr_pkg::RunWidth'(LongRun), move_direction: 1'b0,
                     lower_hall_pos: pick_position(), upper_hall_pos: pick_position()}, 1'b0);
      send_fields(1'b0, 100, edge_total, edge_latch, 1'b0);
      edge_total++;
      for (i = 0; i < LongRun + 3; i++)
         send_fields(1'b1, pos_type'($urandom_range(99)), edge_total, pos_type'($urandom),
                     1'b0);
   endtask

   // one pass of the magnet: low stretch, rising edge, high stretch, often turning round.
   // A broken pass may miss the edge count, glitch low or count an extra edge mid-high.
   task automatic run_pass(input bit broken);
      int      n_low;
      int      n_high;
      int      glitch_at;
      int      i;
      pos_type step;
      n_low = $urandom_range(6, 1);
      n_high = $urandom_range(9, 1);
      step = pos_type'($urandom_range(4096, 1));
      if ($urandom_range(1)) step = -step;
      for (i = 0; i < n_low; i++) begin
         enc_track += step;
         send_fields(1'b0, enc_track, edge_total, edge_latch, rare_error());
      end
      enc_track += step;
      if (!broken || $urandom_range(1)) begin
         edge_total++;
         edge_latch = enc_track;
      end
      if ($urandom_range(99) < 60) step = -step;
      glitch_at = broken ? $urandom_range(n_high - 1) : -1;
      for (i = 0; i < n_high; i++) begin
         if (i == glitch_at) begin
            if ($urandom_range(1))
               send_fields(1'b0, enc_track, edge_total, edge_latch, rare_error());
            else
               edge_total++;
         end
         send_fields(1'b1, enc_track, edge_total, edge_latch, rare_error());
         enc_track += step;
      end
   endtask

   task automatic test_random_motion(input int sender_pct, input int receiver_pct,
                                     input int n_words);
      int stop_at;
      int next_cfg;
      int pick;
      send_idle_pct = sender_pct;
      rsp_idle_pct = receiver_pct;
      stop_at = words_sent + n_words;
      next_cfg = words_sent;
      while (words_sent < stop_at) begin
         if (words_sent >= next_cfg) begin
            apply_config(random_config(), $urandom_range(3) == 0);
            next_cfg = words_sent + $urandom_range(200, 80);
         end
         pick = $urandom_range(99);
         if (pick < 75)
            run_pass(1'b0);
         else if (pick < 88)
            run_pass(1'b1);
         else
            send_fields(1'($urandom), pos_type'($urandom), $urandom, pos_type'($urandom),
                        rare_error());
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      test_first_sample();
      test_saturation_and_registers();
      test_long_high_run();
      test_random_motion(26, 75, 540);
      test_random_motion(75, 26, 540);
      test_random_motion(0, 0, 540);

      wait_for_results();
      repeat (DrainCycles) @(posedge clock);
      if (expected_results.size() != 0)
         report_mismatch("results never delivered", expected_results.size(), '0);
      if (mismatches == 0)
         $display("hall_edge_position_zeroing test passed");
      else
         $display("hall_edge_position_zeroing test failed");
      $finish;
   end

endmodule
